>>> hw/rtl/ffag_pkg.sv
// Package with the widths, payload types and gap test for the first-fit gap search.
`timescale 1ns / 1ps

package ffag_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned SizeBits   = OffsetBits + 1;
  localparam int unsigned AlignBits  = 4;
  // Round-up arithmetic must hold a previous end plus the widest alignment mask.
  localparam int unsigned CalcBits   =
      ((SizeBits > (1 << AlignBits)) ? SizeBits : (1 << AlignBits)) + 1;
  localparam int unsigned ReachBits  = OffsetBits + 2;

  typedef struct packed {
    logic [SizeBits-1:0]   req_size;
    logic [AlignBits-1:0]  align_log2;
    logic                  region_present;
    logic [OffsetBits-1:0] region_start;
    logic [SizeBits-1:0]   region_extent;
    logic                  last_region;
  } ffag_in_t;

  typedef struct packed {
    logic                  fit_found;
    logic [OffsetBits-1:0] fit_offset;
  } ffag_out_t;

  typedef struct packed {
    logic                  fit;
    logic [OffsetBits-1:0] offset;
  } gap_res_t;

  // Tests whether an aligned request fits in the gap from gap_begin to gap_end.
  function automatic gap_res_t try_gap(logic [SizeBits-1:0]  gap_begin,
                                       logic [SizeBits-1:0]  gap_end,
                                       logic [SizeBits-1:0]  req,
                                       logic [AlignBits-1:0] lg);
    logic [CalcBits-1:0]  amask;
    logic [CalcBits-1:0]  aligned;
    logic [ReachBits-1:0] reach;
    gap_res_t             res;
    amask      = (CalcBits'(1) << lg) - CalcBits'(1);
    aligned    = (CalcBits'(gap_begin) + amask) & ~amask;
    reach      = ReachBits'(aligned[OffsetBits-1:0]) + ReachBits'(req);
    res.fit    = (gap_end >= gap_begin) && (aligned[CalcBits-1:OffsetBits] == '0) &&
                 (reach <= ReachBits'(gap_end));
    res.offset = aligned[OffsetBits-1:0];
    return res;
  endfunction

endpackage

>>> hw/rtl/first_fit_aligned_gap_search.sv
// Top level of the first-fit aligned gap search.
`timescale 1ns / 1ps

// Usage: a search is a stream of input transactions, one per used region in
// ascending address order, each carrying the same request size and alignment.
// The transaction with last_region set, or one with region_present clear, ends
// the search: the block then tests the tail gap up to pool_size and returns one
// output transaction with fit_found and the first fitting aligned fit_offset.
// Other input transactions return nothing.
// An accepted transaction sits in the input register, where the gap tests run,
// and the result of a search is then registered in the output register, from
// which it is offered to the receiver.
// Throughput is one input transaction per cycle unless a search end is stalled;
// the running previous region end is updated in that same cycle, which bounds the rate.
// When the receiver stalls, the output register holds its result; the input
// register keeps accepting items that give no result, and an item that ends a
// search waits there, which then drops in_ready_o.
// pool_size is written through cfg_we_i and cfg_wdata_i; write it only while the block
// is idle, as the block does not enforce this. Values above the pool limit are clamped.
// Reset sets pool_size to the full pool, clears the search state and empties both registers.
module first_fit_aligned_gap_search
  import ffag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SizeBits-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffag_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffag_out_t           out_data_o
);

  localparam logic [SizeBits-1:0] PoolLimit = SizeBits'(1) << OffsetBits;

  logic [SizeBits-1:0]   pool_size_q;
  logic                  s1_valid_q;
  ffag_in_t              s1_data_q;
  logic [SizeBits-1:0]   prev_end_q;
  logic                  have_fit_q;
  logic [OffsetBits-1:0] held_offset_q;
  logic                  out_valid_q;
  ffag_out_t             out_data_q;

  logic [SizeBits-1:0]   new_end;
  logic [SizeBits-1:0]   tail_begin;
  gap_res_t              region_gap;
  gap_res_t              tail_gap;
  logic                  fit_before_tail;
  logic [OffsetBits-1:0] offset_before_tail;
  logic                  ends_search;
  logic                  advance;
  ffag_out_t             result;

  assign new_end    = SizeBits'(s1_data_q.region_start) + s1_data_q.region_extent;
  assign region_gap = try_gap(prev_end_q, SizeBits'(s1_data_q.region_start),
                              s1_data_q.req_size, s1_data_q.align_log2);
  assign tail_begin = s1_data_q.region_present ? new_end : prev_end_q;
  assign tail_gap   = try_gap(tail_begin, pool_size_q, s1_data_q.req_size,
                              s1_data_q.align_log2);

  always_comb begin
    fit_before_tail    = have_fit_q;
    offset_before_tail = held_offset_q;
    if (s1_data_q.region_present && !have_fit_q && region_gap.fit) begin
      fit_before_tail    = 1'b1;
      offset_before_tail = region_gap.offset;
    end
    result.fit_found  = fit_before_tail || tail_gap.fit;
    result.fit_offset = fit_before_tail ? offset_before_tail :
                        (tail_gap.fit ? tail_gap.offset : '0);
  end

  assign ends_search = !s1_data_q.region_present || s1_data_q.last_region;
  assign advance     = s1_valid_q && (!ends_search || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= PoolLimit;
    end else if (cfg_we_i) begin
      pool_size_q <= cfg_wdata_i[OffsetBits] ? PoolLimit : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_end_q    <= '0;
      have_fit_q    <= 1'b0;
      held_offset_q <= '0;
    end else if (advance) begin
      if (ends_search) begin
        prev_end_q    <= '0;
        have_fit_q    <= 1'b0;
        held_offset_q <= '0;
      end else begin
        prev_end_q    <= new_end;
        have_fit_q    <= fit_before_tail;
        held_offset_q <= offset_before_tail;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && ends_search) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ends_search) begin
      out_data_q <= result;
    end
  end

endmodule

>>> hw/rtl/ffag_checker.sv
// Port-level assertions for the first-fit gap search and their bind.
`timescale 1ns / 1ps

module ffag_checker
  import ffag_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input ffag_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ffag_out_t out_data_o
);

  logic [2:0] pending_q;
  logic       end_in;
  logic       res_out;

  assign end_in  = in_valid_i && in_ready_o &&
                   (!in_data_i.region_present || in_data_i.last_region);
  assign res_out = out_valid_o && out_ready_i;

  // Searches ended at the input whose result has not yet left the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(end_in) - 3'(res_out);
    end
  end

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("More searches in flight than the two registers can hold.");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("Output transaction offered without a search having ended.");

  a_offset_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fit_found |-> out_data_o.fit_offset == '0)
    else $error("Nonzero offset reported with no fit found.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output transaction changed or dropped.");

endmodule

bind first_fit_aligned_gap_search ffag_checker u_ffag_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
